// ===== rtl/fmssm_pkg.sv =====
// Shared types, codes and constants for the FM shadow and mute sequencer.
// No dependencies; used by every file in rtl/.

package fmssm_pkg;

	// Command codes
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_MUTE   = 2'd1;
	localparam logic [1:0] CMD_UNMUTE = 2'd2;

	localparam logic [8:0] MIX_ADDR     = 9'h007;
	localparam logic [7:0] MIX_MUTED    = 8'h3f;
	localparam logic [7:0] MIX_RESET    = 8'h3f;
	localparam logic [7:0] TL_RESET     = 8'h7f;
	localparam logic [7:0] ALG_RESET    = 8'h00;
	localparam logic [3:0] TL_ADDR_HI   = 4'h4;   // (addr & 0xF0) == 0x40
	localparam logic [5:0] ALG_ADDR_HI  = 6'h2c;  // (addr & 0xFC) == 0xB0
	localparam logic signed [8:0] VOL_MUTE   = -9'sd127;
	localparam logic signed [8:0] VOL_UNMUTE = 9'sd0;
	localparam logic [6:0] LEVEL_MAX    = 7'h7f;

	localparam int unsigned NUM_TL  = 32;
	localparam int unsigned NUM_ALG = 8;
	localparam logic [2:0] LAST_CH_SLOT = 3'd5;
	localparam logic [1:0] LAST_OP_SLOT = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [8:0] reg_addr;
		logic [7:0] reg_data;
	} fmssm_in_t;

	typedef struct packed {
		logic [8:0] out_addr;
		logic [7:0] out_data;
		logic       last;
	} fmssm_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_LEVELS
	} fmssm_state_t;

	// Carrier operators per algorithm, bit k = operator slot k
	function automatic logic [3:0] carrier_mask(input logic [2:0] alg);
		logic [3:0] m;
		case (alg)
			3'd4:    m = 4'hc;
			3'd5:    m = 4'he;
			3'd6:    m = 4'he;
			3'd7:    m = 4'hf;
			default: m = 4'h8;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/fmssm_level_unit.sv =====
// Shared level unit: shadow total level minus volume, saturated to 0..127.
// Depends on fmssm_pkg.

module fmssm_level_unit (
	input  logic [6:0] level,
	input  logic       mute,
	output logic [6:0] result
);

	logic signed [8:0] vol;
	logic signed [8:0] diff;

	assign vol  = mute ? fmssm_pkg::VOL_MUTE : fmssm_pkg::VOL_UNMUTE;
	assign diff = $signed({2'b00, level}) - vol;

	always_comb begin
		if (diff < 9'sd0) begin
			result = 7'd0;
		end else if (diff > $signed({2'b00, fmssm_pkg::LEVEL_MAX})) begin
			result = fmssm_pkg::LEVEL_MAX;
		end else begin
			result = diff[6:0];
		end
	end

endmodule

// ===== rtl/fm_synth_shadow_mute_sequencer_top.sv =====
// Top level of the FM shadow and mute sequencer.
// Depends on fmssm_pkg and fmssm_level_unit.

// Front end for an FM sound chip. A register write item (cmd 0) updates the
// mixer, total-level or algorithm shadow it hits and is passed straight on
// as one write with last set; writes flow at one item per cycle while the
// output is not stalled. A mute (cmd 1) or unmute (cmd 2) item loads the
// mixer write into the output register on accept, then a small sequencer
// walks channels 0,4,1,5,2,6 and four operator slots each, one slot per
// cycle unless a carrier slot waits on a stalled output, sending every
// carrier slot through the shared saturating level unit. New items stall
// until the walk is done; slots that are not carriers emit nothing.
// cmd 3, and any item while enabled is 0, is taken and dropped. The config
// port is always ready and holds only the enabled bit (reset 0).

module fm_synth_shadow_mute_sequencer_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  fmssm_pkg::fmssm_in_t  req,
	output logic                  wr_valid,
	input  logic                  wr_stall,
	output fmssm_pkg::fmssm_out_t wr
);

	fmssm_pkg::fmssm_state_t state_q, state_next;

	logic       enabled_q;
	logic       mute_q;
	logic [2:0] ch_slot_q;   // position in channel order 0,4,1,5,2,6
	logic [1:0] op_slot_q;
	logic [7:0] mix_q;
	logic [7:0] tl_q  [fmssm_pkg::NUM_TL];
	logic [7:0] alg_q [fmssm_pkg::NUM_ALG];

	logic                  wr_valid_q;
	fmssm_pkg::fmssm_out_t wr_q;
	fmssm_pkg::fmssm_out_t wr_next;
	logic                  wr_load;
	logic                  out_free;

	logic       accept;
	logic       take;      // accepted and acted on
	logic       is_write;
	logic       is_mute_cmd;
	logic       slot_adv;
	logic       final_slot;
	logic [2:0] ch;
	logic [3:0] mask;
	logic       carrier;
	logic [6:0] level;

	assign cfg_ready = 1'b1;
	assign wr_valid  = wr_valid_q;
	assign wr        = wr_q;

	assign out_free  = !wr_valid_q || !wr_stall;
	assign req_stall = (state_q != fmssm_pkg::ST_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign take      = accept && enabled_q;
	assign is_write  = req.cmd == fmssm_pkg::CMD_WRITE;
	assign is_mute_cmd = (req.cmd == fmssm_pkg::CMD_MUTE) || (req.cmd == fmssm_pkg::CMD_UNMUTE);

	// slot decode: channel bit 2 alternates, low bits step every pair
	assign ch         = {ch_slot_q[0], ch_slot_q[2:1]};
	assign mask       = fmssm_pkg::carrier_mask(alg_q[ch][2:0]);
	assign carrier    = mask[op_slot_q];
	assign final_slot = (ch_slot_q == fmssm_pkg::LAST_CH_SLOT) &&
		(op_slot_q == fmssm_pkg::LAST_OP_SLOT);
	assign slot_adv   = (state_q == fmssm_pkg::ST_LEVELS) && (!carrier || out_free);

	fmssm_level_unit u_level (
		.level  (tl_q[{ch[2], op_slot_q, ch[1:0]}][6:0]),
		.mute   (mute_q),
		.result (level)
	);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			fmssm_pkg::ST_IDLE: begin
				if (take && is_mute_cmd) state_next = fmssm_pkg::ST_LEVELS;
			end
			fmssm_pkg::ST_LEVELS: begin
				if (slot_adv && final_slot) state_next = fmssm_pkg::ST_IDLE;
			end
			default: state_next = fmssm_pkg::ST_IDLE;
		endcase
	end

	// output item
	always_comb begin
		wr_load = 1'b0;
		wr_next = wr_q;
		case (state_q)
			fmssm_pkg::ST_IDLE: begin
				if (take && is_write) begin
					wr_load = 1'b1;
					wr_next.out_addr = req.reg_addr;
					wr_next.out_data = req.reg_data;
					wr_next.last     = 1'b1;
				end else if (take && is_mute_cmd) begin
					wr_load = 1'b1;
					wr_next.out_addr = fmssm_pkg::MIX_ADDR;
					wr_next.out_data = (req.cmd == fmssm_pkg::CMD_MUTE) ?
						fmssm_pkg::MIX_MUTED : mix_q;
					wr_next.last     = 1'b0;
				end
			end
			fmssm_pkg::ST_LEVELS: begin
				if (carrier && out_free) begin
					wr_load = 1'b1;
					wr_next.out_addr = {ch[2], fmssm_pkg::TL_ADDR_HI, op_slot_q, ch[1:0]};
					wr_next.out_data = {1'b0, level};
					wr_next.last     = final_slot;
				end
			end
			default: wr_load = 1'b0;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fmssm_pkg::ST_IDLE;
			enabled_q  <= 1'b0;
			wr_valid_q <= 1'b0;
			mute_q     <= 1'b0;
			ch_slot_q  <= '0;
			op_slot_q  <= '0;
		end else begin
			state_q <= state_next;
			if (cfg_valid) enabled_q <= cfg_data;
			if (out_free) wr_valid_q <= wr_load;
			if (take && is_mute_cmd) begin
				mute_q    <= req.cmd == fmssm_pkg::CMD_MUTE;
				ch_slot_q <= '0;
				op_slot_q <= '0;
			end else if (slot_adv) begin
				op_slot_q <= op_slot_q + 2'd1;
				if (op_slot_q == fmssm_pkg::LAST_OP_SLOT) ch_slot_q <= ch_slot_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_load) wr_q <= wr_next;
	end

	// shadows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= fmssm_pkg::MIX_RESET;
			for (int i = 0; i < fmssm_pkg::NUM_TL; i++) tl_q[i] <= fmssm_pkg::TL_RESET;
			for (int i = 0; i < fmssm_pkg::NUM_ALG; i++) alg_q[i] <= fmssm_pkg::ALG_RESET;
		end else if (take && is_write) begin
			if (req.reg_addr == fmssm_pkg::MIX_ADDR) begin
				mix_q <= req.reg_data;
			end else if (req.reg_addr[7:4] == fmssm_pkg::TL_ADDR_HI) begin
				tl_q[{req.reg_addr[8], req.reg_addr[3:0]}] <= req.reg_data;
			end else if (req.reg_addr[7:2] == fmssm_pkg::ALG_ADDR_HI) begin
				alg_q[{req.reg_addr[8], req.reg_addr[1:0]}] <= req.reg_data;
			end
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the FM shadow and mute sequencer.
// Depends on rtl/fmssm_pkg.sv and rtl/fm_synth_shadow_mute_sequencer_top.sv.
// Predicts the chip writes per item and checks them in order at the output.
`timescale 1ns / 100ps

module tb_top;
	import fmssm_pkg::*;

	localparam logic [1:0] CMD_UNDEFINED = 2'd3;
	localparam logic [8:0] LOW_TL_BASE   = 9'h040;
	localparam logic [8:0] HIGH_TL_BASE  = 9'h140;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         MAX_BURST     = 25;

	// carrier operators per algorithm, bit k = operator slot k
	localparam logic [3:0] CARRIERS [8] = '{4'h8, 4'h8, 4'h8, 4'h8, 4'hc, 4'he, 4'he, 4'hf};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data  = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	fmssm_in_t  req       = '0;
	logic       wr_valid;
	logic       wr_stall  = 1'b0;
	fmssm_out_t wr;

	fm_synth_shadow_mute_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.wr_valid  (wr_valid),
		.wr_stall  (wr_stall),
		.wr        (wr)
	);

	always #6 clk = ~clk;

	// Own copy of the chip shadows and the enable bit
	logic       chip_enabled = 1'b0;
	logic [7:0] mix_copy     = MIX_RESET;
	logic [7:0] level_copy [32];
	logic [7:0] alg_copy [8];

	fmssm_in_t  pending_items [$];
	fmssm_out_t expected_writes [$];
	int         items_queued = 0;
	int         items_taken  = 0;
	int         error_count  = 0;
	int         gap_left     = 0;
	int         hold_left    = 0;
	logic       steady       = 1'b0;  // set: neither side idles

	initial begin
		foreach (level_copy[i]) level_copy[i] = TL_RESET;
		foreach (alg_copy[i]) alg_copy[i] = ALG_RESET;
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 4);
	endfunction

	// Update the shadows for one accepted item and queue the chip writes it causes
	function automatic void model_chip_writes(input fmssm_in_t item);
		fmssm_out_t burst [MAX_BURST];
		int         n;
		int         slot;
		int         k;
		int         lvl;
		logic [2:0] ch;
		logic [3:0] mask;
		logic [3:0] offset;
		logic       mute;
		n = 0;
		if (!chip_enabled)
			return;
		case (item.cmd)
			CMD_WRITE: begin
				if (item.reg_addr == MIX_ADDR)
					mix_copy = item.reg_data;
				else if (item.reg_addr[7:4] == TL_ADDR_HI)
					level_copy[{item.reg_addr[8], item.reg_addr[3:0]}] = item.reg_data;
				else if (item.reg_addr[7:2] == ALG_ADDR_HI)
					alg_copy[{item.reg_addr[8], item.reg_addr[1:0]}] = item.reg_data;
				burst[0] = '{item.reg_addr, item.reg_data, 1'b0};
				n = 1;
			end
			CMD_MUTE, CMD_UNMUTE: begin
				mute = (item.cmd == CMD_MUTE);
				burst[0] = '{MIX_ADDR, mute ? MIX_MUTED : mix_copy, 1'b0};
				n = 1;
				// channel order 0,4,1,5,2,6
				for (slot = 0; slot < 6; slot++) begin
					ch = {slot[0], slot[2:1]};
					mask = CARRIERS[alg_copy[ch][2:0]];
					for (k = 0; k < 4; k++) begin
						if (mask[k]) begin
							offset = {k[1:0], ch[1:0]};
							lvl = int'(level_copy[{ch[2], offset}][6:0])
								- (mute ? int'(VOL_MUTE) : int'(VOL_UNMUTE));
							if (lvl < 0)
								lvl = 0;
							else if (lvl > int'(LEVEL_MAX))
								lvl = int'(LEVEL_MAX);
							burst[n] = '{(ch[2] ? HIGH_TL_BASE : LOW_TL_BASE) + offset,
								8'(lvl), 1'b0};
							n++;
						end
					end
				end
			end
			default: ;
		endcase
		if (n > 0)
			burst[n - 1].last = 1'b1;
		for (k = 0; k < n; k++)
			expected_writes.push_back(burst[k]);
	endfunction

	// Mostly writes into the shadowed ranges and mute/unmute, with some noise
	function automatic fmssm_in_t random_item();
		fmssm_in_t item;
		int        pick;
		logic      bank;
		pick = $urandom_range(0, 99);
		bank = 1'($urandom);
		item.cmd      = CMD_WRITE;
		item.reg_addr = 9'($urandom_range(0, 511));
		item.reg_data = 8'($urandom_range(0, 255));
		if (pick < 30)
			item.reg_addr = {bank, TL_ADDR_HI, 4'($urandom)};
		else if (pick < 45)
			item.reg_addr = {bank, ALG_ADDR_HI, 2'($urandom)};
		else if (pick < 50)
			item.reg_addr = MIX_ADDR;
		else if (pick < 62)
			item.cmd = CMD_MUTE;
		else if (pick < 74)
			item.cmd = CMD_UNMUTE;
		else if (pick >= 92)
			item.cmd = CMD_UNDEFINED;
		return item;
	endfunction

	// Driver: one item at a time from the pending queue, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left  = 0;
		end else begin
			if (req_valid && !req_stall) begin
				model_chip_writes(req);
				items_taken++;
			end
			// a stalled item must stay put
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req       <= pending_items.pop_front();
					req_valid <= 1'b1;
					gap_left  = draw_wait();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted chip write, then stalls for a random spell
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_stall  <= 1'b0;
			hold_left = 0;
		end else begin
			if (wr_valid && !wr_stall) begin
				if (expected_writes.size() == 0) begin
					$display("%0t: unexpected write addr %h data %h last %b",
						$time, wr.out_addr, wr.out_data, wr.last);
					error_count++;
				end else begin
					if (wr.out_addr !== expected_writes[0].out_addr) begin
						$display("%0t: out_addr expected %h got %h",
							$time, expected_writes[0].out_addr, wr.out_addr);
						error_count++;
					end
					if (wr.out_data !== expected_writes[0].out_data) begin
						$display("%0t: out_data expected %h got %h",
							$time, expected_writes[0].out_data, wr.out_data);
						error_count++;
					end
					if (wr.last !== expected_writes[0].last) begin
						$display("%0t: last expected %b got %b",
							$time, expected_writes[0].last, wr.last);
						error_count++;
					end
					void'(expected_writes.pop_front());
				end
				hold_left = draw_wait();
			end
			if (hold_left > 0) begin
				hold_left--;
				wr_stall <= 1'b1;
			end else begin
				wr_stall <= 1'b0;
			end
		end
	end

	task automatic queue_item(input fmssm_in_t item);
		pending_items.push_back(item);
		items_queued++;
	endtask

	task automatic queue_random(input int count);
		repeat (count) queue_item(random_item());
	endtask

	// Every item taken and every write seen, then let the sequencer run dry
	task automatic wait_quiet();
		while (items_taken != items_queued || expected_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		chip_enabled = value;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Out of reset the chip is disabled: all of these are dropped
		queue_item('{CMD_WRITE, MIX_ADDR, 8'h00});
		queue_item('{CMD_MUTE, 9'h000, 8'h00});
		queue_item('{CMD_UNMUTE, 9'h1ff, 8'hff});
		queue_item('{CMD_WRITE, 9'h0b0, 8'h07});
		wait_quiet();

		write_enable(1'b1);
		// reset shadows: one carrier per channel, full attenuation
		queue_item('{CMD_UNMUTE, 9'h000, 8'h00});
		queue_item('{CMD_MUTE, 9'h1ff, 8'hff});
		queue_item('{CMD_WRITE, MIX_ADDR, 8'ha5});
		// upper-bank 0x07 is not the mixer
		queue_item('{CMD_WRITE, 9'h107, 8'h5a});
		// algorithms covering every carrier mask
		queue_item('{CMD_WRITE, 9'h0b0, 8'h07});
		queue_item('{CMD_WRITE, 9'h0b1, 8'h04});
		queue_item('{CMD_WRITE, 9'h0b2, 8'h05});
		queue_item('{CMD_WRITE, 9'h1b0, 8'h06});
		queue_item('{CMD_WRITE, 9'h1b1, 8'hff});
		queue_item('{CMD_WRITE, 9'h1b2, 8'hf8});
		queue_item('{CMD_WRITE, 9'h1b3, 8'h03});  // channel 7 never replayed
		// levels: zero, top bit set, mid values, upper bank
		queue_item('{CMD_WRITE, 9'h040, 8'h00});
		queue_item('{CMD_WRITE, 9'h044, 8'hff});
		queue_item('{CMD_WRITE, 9'h048, 8'h80});
		queue_item('{CMD_WRITE, 9'h04c, 8'h33});
		queue_item('{CMD_WRITE, 9'h14f, 8'h12});
		queue_item('{CMD_WRITE, 9'h141, 8'h01});
		queue_item('{CMD_WRITE, 9'h000, 8'h00});
		queue_item('{CMD_WRITE, 9'h1ff, 8'hff});
		queue_item('{CMD_UNDEFINED, 9'h1ff, 8'hff});
		queue_item('{CMD_UNMUTE, 9'h155, 8'haa});
		queue_item('{CMD_MUTE, 9'h0aa, 8'h55});
		queue_item('{CMD_WRITE, 9'h0bc, 8'h11});  // outside the algorithm range 0xB0-0xB3
		queue_item('{CMD_UNMUTE, 9'h000, 8'h00});
		queue_random(20);
		wait_quiet();

		// Disabled again: random traffic must leave the shadows alone
		write_enable(1'b0);
		queue_random(12);
		wait_quiet();

		// Re-enabled: a back-to-back stretch, then random gaps and stalls
		write_enable(1'b1);
		steady = 1'b1;
		queue_random(30);
		wait_quiet();
		steady = 1'b0;
		queue_random(30);
		wait_quiet();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fmssm_pkg.sv
rtl/fmssm_level_unit.sv
rtl/fm_synth_shadow_mute_sequencer_top.sv
test/tb_top.sv
